FILE: design/ibtm_pkg.sv
`default_nettype none
package ibtm_pkg;
    localparam int CoordBits = 12;
    localparam int ScoreBits = 17;

    localparam logic [1:0] KIND_NEW      = 2'd0;
    localparam logic [1:0] KIND_AVERAGED = 2'd1;
    localparam logic [1:0] KIND_REPLACED = 2'd2;

    localparam logic CMD_BOX = 1'b0;
    localparam logic CMD_EOF = 1'b1;

    localparam logic [0:0] REG_MIN_SCORE = 1'd0;
    localparam logic [0:0] REG_MAX_SCORE = 1'd1;

    typedef struct packed {
        logic                 cmd;
        logic [CoordBits-1:0] box_x;
        logic [CoordBits-1:0] box_y;
        logic [CoordBits-1:0] box_width;
        logic [CoordBits-1:0] box_height;
    } in_item_t;

    typedef struct packed {
        logic [CoordBits-1:0] out_x;
        logic [CoordBits-1:0] out_y;
        logic [CoordBits-1:0] out_width;
        logic [CoordBits-1:0] out_height;
        logic [1:0]           match_kind;
    } out_item_t;
endpackage
`default_nettype wire

FILE: design/iou_box_track_matcher_unit.sv
`default_nettype none
// Sequence: a box request runs through the track scan, the pipeline drain, a decision,
// a box read, a merge and a handoff into the output register; the handoff waits
// while the output register holds a stalled result.
// Throughput: one box at a time, the next accepted as the result appears; an
// end-of-frame request is taken while idle and leaves the unit idle.
// Reset: thresholds take defaults, counts and taken flags clear; the RAM is not reset.
module iou_box_track_matcher_unit #(
    parameter int MAX_TRACKS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire ibtm_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output ibtm_pkg::out_item_t       out_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [ibtm_pkg::ScoreBits-1:0] cfg_data
);
    localparam int CB    = ibtm_pkg::CoordBits;
    localparam int SB    = ibtm_pkg::ScoreBits;
    localparam int BOXW  = 4 * CB;
    localparam int TIDX  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNTW  = $clog2(MAX_TRACKS + 1);
    // The bank bit sits above the track index.
    localparam int ADDRW = TIDX + 1;
    localparam int AREAW = 2 * (CB + 1) + 1;   // union can exceed one area
    localparam int PRODW = AREAW + SB;

    // Sequencer codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_READB  = 3'd4;
    localparam logic [2:0] ST_MERGE  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [SB-1:0]         min_reg, max_reg;
    logic                  bank_reg;
    logic [CNTW-1:0]       prev_cnt_reg, cur_cnt_reg;
    logic [MAX_TRACKS-1:0] taken_reg;

    logic [CB-1:0] nx_reg, ny_reg, nw_reg, nh_reg;
    logic [CNTW-1:0] scan_reg;        // address index issued to RAM
    logic [2:0]      drain_reg;       // counts down while the pipe flushes

    // Pipeline: s1 = RAM data valid, s2 = overlap terms, s3 = areas.
    logic            s1_v_reg, s2_v_reg, s3_v_reg;
    logic [TIDX-1:0] s1_i_reg, s2_i_reg, s3_i_reg;
    logic [CB:0]     s2_iw_reg, s2_ih_reg;
    logic [2*CB-1:0] s2_pa_reg;
    logic [2*CB:0]   s3_in_reg;
    logic [AREAW-1:0] s3_un_reg;

    // Best candidate: compared by cross-products.
    logic             have_reg;
    logic [TIDX-1:0]  best_reg;
    logic [2*CB:0]    best_in_reg;
    logic [AREAW-1:0] best_un_reg;

    logic [1:0]      kind_reg;
    ibtm_pkg::out_item_t res_reg;

    // Output register: a result waiting here does not hold up the next box until that box reaches its handoff.
    logic                out_valid_reg;
    ibtm_pkg::out_item_t out_reg;
    logic                handoff;

    logic [ADDRW-1:0] rd_addr, wr_addr;
    logic [BOXW-1:0]  rd_data, wr_data;
    logic             wr_en;

    ibtm_ram #(.WIDTH(BOXW), .DEPTH(2 ** ADDRW)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic accept;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    // The merged box moves on once the output register is empty or being emptied.
    assign handoff   = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Track box fields from the RAM word.
    logic [CB-1:0] tx, ty, tw, th;
    assign tx = rd_data[CB-1:0];
    assign ty = rd_data[2*CB-1:CB];
    assign tw = rd_data[3*CB-1:2*CB];
    assign th = rd_data[4*CB-1:3*CB];

    // Overlap extents for stage two.
    logic [CB:0] lo_x, hi_x, lo_y, hi_y, pxe, qxe, pye, qye;
    always_comb
    begin
        lo_x = (tx > nx_reg) ? {1'b0, tx} : {1'b0, nx_reg};
        lo_y = (ty > ny_reg) ? {1'b0, ty} : {1'b0, ny_reg};
        pxe  = {1'b0, tx} + {1'b0, tw};
        qxe  = {1'b0, nx_reg} + {1'b0, nw_reg};
        pye  = {1'b0, ty} + {1'b0, th};
        qye  = {1'b0, ny_reg} + {1'b0, nh_reg};
        hi_x = (pxe < qxe) ? pxe : qxe;
        hi_y = (pye < qye) ? pye : qye;
    end

    // Stage three: intersection and union.
    logic [2*CB:0]    inter_w;
    logic [2*CB-1:0]  qa_w;
    logic [AREAW-1:0] uni_w;
    always_comb
    begin
        inter_w = (2*CB+1)'(s2_iw_reg * s2_ih_reg);
        qa_w    = nw_reg * nh_reg;
        uni_w   = AREAW'(s2_pa_reg) + AREAW'(qa_w) - AREAW'(inter_w);
    end

    // Candidate compare: it*best_un > best_in*ut, split across two multipliers.
    logic [AREAW-1:0]    in_e, un_e;
    logic [2*AREAW-1:0]  lhs, rhs;
    logic                better;
    always_comb
    begin
        in_e = (s3_un_reg == '0) ? '0 : AREAW'(s3_in_reg);
        un_e = (s3_un_reg == '0) ? AREAW'(1) : s3_un_reg;
        lhs  = AREAW'(in_e) * best_un_reg;
        rhs  = AREAW'(best_in_reg) * un_e;
        better = !have_reg || (lhs > rhs);
    end

    // Threshold compares against Q1.16.
    logic [PRODW-1:0] scaled_in, min_prod, max_prod;
    logic             match, replace;
    always_comb
    begin
        scaled_in = {PRODW'(best_in_reg)} << 16;
        min_prod  = PRODW'(min_reg) * PRODW'(best_un_reg);
        max_prod  = PRODW'(max_reg) * PRODW'(best_un_reg);
        match     = have_reg && (scaled_in > min_prod);
        replace   = !(scaled_in < max_prod);
    end

    logic [TIDX-1:0] scan_idx;
    assign scan_idx = scan_reg[TIDX-1:0];
    logic scan_live;
    assign scan_live = (state_reg == ST_SCAN) && (scan_reg < prev_cnt_reg);

    always_comb
    begin
        if (state_reg == ST_READB || state_reg == ST_DECIDE)
        begin
            rd_addr = {~bank_reg, best_reg};
        end
        else
        begin
            rd_addr = {~bank_reg, scan_idx};
        end
        wr_addr = {bank_reg, cur_cnt_reg[TIDX-1:0]};
        wr_en   = handoff && (cur_cnt_reg < CNTW'(MAX_TRACKS));
        wr_data = {res_reg.out_height, res_reg.out_width, res_reg.out_y, res_reg.out_x};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.cmd == ibtm_pkg::CMD_BOX)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg >= prev_cnt_reg || scan_reg == CNTW'(MAX_TRACKS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: state_next = ST_READB;
            ST_READB:  state_next = ST_MERGE;
            ST_MERGE:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (handoff)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= SB'(19661);
            max_reg       <= SB'(62259);
            bank_reg      <= 1'b0;
            prev_cnt_reg  <= '0;
            cur_cnt_reg   <= '0;
            taken_reg     <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            have_reg      <= 1'b0;
            scan_reg      <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    ibtm_pkg::REG_MIN_SCORE: min_reg <= cfg_data;
                    ibtm_pkg::REG_MAX_SCORE: max_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept && in_data.cmd == ibtm_pkg::CMD_EOF)
            begin
                prev_cnt_reg <= cur_cnt_reg;
                bank_reg     <= ~bank_reg;
                cur_cnt_reg  <= '0;
                taken_reg    <= '0;
            end
            if (accept)
            begin
                scan_reg  <= '0;
                have_reg  <= 1'b0;
                drain_reg <= 3'd3;
            end
            if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (state_reg == ST_DRAIN)
            begin
                drain_reg <= drain_reg - 1'b1;
            end
            // An untaken, existing track issues a read; its data returns next cycle.
            s1_v_reg <= scan_live && !taken_reg[scan_idx];
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            if (s3_v_reg && better)
            begin
                have_reg <= 1'b1;
            end
            if (state_reg == ST_DECIDE && match)
            begin
                taken_reg[best_reg] <= 1'b1;
            end
            if (handoff && cur_cnt_reg < CNTW'(MAX_TRACKS))
            begin
                cur_cnt_reg <= cur_cnt_reg + 1'b1;
            end
            out_valid_reg <= handoff || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            nx_reg <= in_data.box_x;
            ny_reg <= in_data.box_y;
            nw_reg <= in_data.box_width;
            nh_reg <= in_data.box_height;
        end
        s1_i_reg  <= scan_idx;
        s2_i_reg  <= s1_i_reg;
        s3_i_reg  <= s2_i_reg;
        s2_iw_reg <= (hi_x > lo_x) ? hi_x - lo_x : '0;
        s2_ih_reg <= (hi_y > lo_y) ? hi_y - lo_y : '0;
        s2_pa_reg <= tw * th;
        s3_in_reg <= inter_w;
        s3_un_reg <= uni_w;
        if (s3_v_reg && better)
        begin
            best_reg    <= s3_i_reg;
            best_in_reg <= (s3_un_reg == '0) ? '0 : s3_in_reg;
            best_un_reg <= un_e;
        end
        if (state_reg == ST_DECIDE)
        begin
            if (!match)
            begin
                kind_reg <= ibtm_pkg::KIND_NEW;
            end
            else if (replace)
            begin
                kind_reg <= ibtm_pkg::KIND_REPLACED;
            end
            else
            begin
                kind_reg <= ibtm_pkg::KIND_AVERAGED;
            end
        end
        if (state_reg == ST_MERGE)
        begin
            res_reg.match_kind <= kind_reg;
            if (kind_reg == ibtm_pkg::KIND_AVERAGED)
            begin
                res_reg.out_x      <= CB'(({1'b0, tx} + {1'b0, nx_reg}) >> 1);
                res_reg.out_y      <= CB'(({1'b0, ty} + {1'b0, ny_reg}) >> 1);
                res_reg.out_width  <= CB'(({1'b0, tw} + {1'b0, nw_reg}) >> 1);
                res_reg.out_height <= CB'(({1'b0, th} + {1'b0, nh_reg}) >> 1);
            end
            else
            begin
                res_reg.out_x      <= nx_reg;
                res_reg.out_y      <= ny_reg;
                res_reg.out_width  <= nw_reg;
                res_reg.out_height <= nh_reg;
            end
        end
        if (handoff)
        begin
            out_reg <= res_reg;
        end
    end
endmodule
`default_nettype wire

FILE: design/ibtm_ram.sv
`default_nettype none
module ibtm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Self-checking bench for the IoU box track matcher.
    // Detected boxes arrive in frames closed by end-of-frame requests. Each accepted
    // request runs through a local model of the tracker (two banks of kept boxes,
    // per-track taken flags, exact IoU comparison by cross-multiplication), and each
    // result is checked against the oldest prediction.

    localparam int MaxTracks = 16;
    localparam longint unsigned Q16One = 65536;

    typedef struct packed {
        logic [ibtm_pkg::CoordBits-1:0] x;
        logic [ibtm_pkg::CoordBits-1:0] y;
        logic [ibtm_pkg::CoordBits-1:0] w;
        logic [ibtm_pkg::CoordBits-1:0] h;
    } box_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    ibtm_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    ibtm_pkg::out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [0:0] cfg_index;
    logic [ibtm_pkg::ScoreBits-1:0] cfg_data;

    iou_box_track_matcher_unit #(
        .MAX_TRACKS(MaxTracks)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Requests still to be driven, and results the tracker model has predicted.
    ibtm_pkg::in_item_t  pending_requests[$];
    ibtm_pkg::out_item_t expected_tracks[$];

    // Tracker model state. Bank select picks the bank being filled this frame;
    // the other bank holds the previous frame's tracks.
    box_t                    track_bank[2*MaxTracks];
    logic                    fill_bank = 1'b0;
    int unsigned             prev_tracks = 0;
    int unsigned             cur_tracks = 0;
    logic [MaxTracks-1:0]    taken = '0;
    logic [ibtm_pkg::ScoreBits-1:0] min_iou = 17'd19661;
    logic [ibtm_pkg::ScoreBits-1:0] max_iou = 17'd62259;

    int errors = 0;
    int n_new = 0;
    int n_averaged = 0;
    int n_replaced = 0;
    int n_frames = 0;
    int n_cfg = 0;

    // Intersection and union areas of two boxes. Two empty boxes score zero.
    task automatic box_overlap(input box_t a, input box_t b,
                               output longint unsigned inter,
                               output longint unsigned uni);
        longint unsigned lo_x, hi_x, lo_y, hi_y, iw, ih;
        lo_x = (a.x > b.x) ? a.x : b.x;
        hi_x = ((a.x + 13'(0) + a.w) < (b.x + 13'(0) + b.w)) ?
               (a.x + 13'(0) + a.w) : (b.x + 13'(0) + b.w);
        lo_y = (a.y > b.y) ? a.y : b.y;
        hi_y = ((a.y + 13'(0) + a.h) < (b.y + 13'(0) + b.h)) ?
               (a.y + 13'(0) + a.h) : (b.y + 13'(0) + b.h);
        iw = (hi_x > lo_x) ? hi_x - lo_x : 0;
        ih = (hi_y > lo_y) ? hi_y - lo_y : 0;
        inter = iw * ih;
        uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
        if (uni == 0)
        begin
            inter = 0;
            uni = 1;
        end
    endtask

    // Apply one accepted request to the tracker model.
    task automatic track_request(input ibtm_pkg::in_item_t req);
        box_t fresh, old, kept;
        ibtm_pkg::out_item_t res;
        longint unsigned it, ut, best_in, best_un;
        int best;
        bit found;
        int prev_base, cur_base;
        if (req.cmd == ibtm_pkg::CMD_EOF)
        begin
            prev_tracks = cur_tracks;
            fill_bank = ~fill_bank;
            cur_tracks = 0;
            taken = '0;
            n_frames++;
            return;
        end
        fresh = '{req.box_x, req.box_y, req.box_width, req.box_height};
        prev_base = fill_bank ? 0 : MaxTracks;
        cur_base = fill_bank ? MaxTracks : 0;
        found = 0;
        best = 0;
        best_in = 0;
        best_un = 1;
        for (int i = 0; i < prev_tracks; i++)
        begin
            if (!taken[i])
            begin
                box_overlap(track_bank[prev_base + i], fresh, it, ut);
                // Strictly better only, so ties keep the lowest index.
                if (!found || it * best_un > best_in * ut)
                begin
                    found = 1;
                    best = i;
                    best_in = it;
                    best_un = ut;
                end
            end
        end
        kept = fresh;
        res.match_kind = ibtm_pkg::KIND_NEW;
        if (found && best_in * Q16One > longint'(min_iou) * best_un)
        begin
            taken[best] = 1'b1;
            if (best_in * Q16One < longint'(max_iou) * best_un)
            begin
                old = track_bank[prev_base + best];
                kept.x = ibtm_pkg::CoordBits'((old.x + 13'(0) + fresh.x) >> 1);
                kept.y = ibtm_pkg::CoordBits'((old.y + 13'(0) + fresh.y) >> 1);
                kept.w = ibtm_pkg::CoordBits'((old.w + 13'(0) + fresh.w) >> 1);
                kept.h = ibtm_pkg::CoordBits'((old.h + 13'(0) + fresh.h) >> 1);
                res.match_kind = ibtm_pkg::KIND_AVERAGED;
            end
            else
                res.match_kind = ibtm_pkg::KIND_REPLACED;
        end
        // A full list still emits the box but does not keep it.
        if (cur_tracks < MaxTracks)
        begin
            track_bank[cur_base + cur_tracks] = kept;
            cur_tracks++;
        end
        res.out_x = kept.x;
        res.out_y = kept.y;
        res.out_width = kept.w;
        res.out_height = kept.h;
        expected_tracks = {expected_tracks, res};
    endtask

    // Clock and a single reset at the start of the run.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Input and output sampling. Requests are predicted the moment they are
    // accepted; results are checked against the oldest prediction.
    bit request_taken = 0;

    always @(posedge clk)
    begin
        request_taken = in_valid && !in_stall;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == ibtm_pkg::REG_MIN_SCORE)
                min_iou = cfg_data;
            else
                max_iou = cfg_data;
            n_cfg++;
        end
        if (rst_n && request_taken)
            track_request(in_data);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tracks.size() == 0)
            begin
                $display("%0t: unexpected result %p", $realtime, out_data);
                errors++;
            end
            else
            begin
                ibtm_pkg::out_item_t exp_res;
                exp_res = expected_tracks[0];
                expected_tracks.delete(0);
                if (out_data.out_x !== exp_res.out_x || out_data.out_y !== exp_res.out_y ||
                    out_data.out_width !== exp_res.out_width ||
                    out_data.out_height !== exp_res.out_height ||
                    out_data.match_kind !== exp_res.match_kind)
                begin
                    $display("%0t: mismatch expected %p actual %p",
                             $realtime, exp_res, out_data);
                    errors++;
                end
                else
                begin
                    case (exp_res.match_kind)
                        ibtm_pkg::KIND_NEW:      n_new++;
                        ibtm_pkg::KIND_AVERAGED: n_averaged++;
                        default:                 n_replaced++;
                    endcase
                end
            end
        end
    end

    // Request driver: bursts of random length with random gaps in between,
    // sometimes long stretches with no gaps at all. A request is held until it
    // has been accepted.
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !request_taken)
            begin
                // Hold the stalled request unchanged.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                in_data <= pending_requests[0];
                pending_requests.delete(0);
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 20);
                    gap_left = $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result receiver: its own stall pattern of random runs.
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
                stall_left--;
            else
            begin
                case ($urandom_range(0, 5))
                    0, 1:
                    begin
                        out_stall <= 1'b1;
                        stall_left = $urandom_range(0, 12);
                    end
                    2:
                    begin
                        out_stall <= 1'b0;
                        stall_left = $urandom_range(50, 200);
                    end
                    default:
                    begin
                        out_stall <= 1'($urandom_range(0, 1));
                        stall_left = $urandom_range(0, 6);
                    end
                endcase
            end
        end
    end

    // Stimulus side: remembers the boxes of the last frame so that most new
    // boxes land near an existing track.
    ibtm_pkg::in_item_t last_frame[$];
    ibtm_pkg::in_item_t this_frame[$];

    function automatic logic [ibtm_pkg::CoordBits-1:0] nudge(
        logic [ibtm_pkg::CoordBits-1:0] v, int span);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * span)) - span;
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        return ibtm_pkg::CoordBits'(t);
    endfunction

    function automatic ibtm_pkg::in_item_t make_box(
        logic [ibtm_pkg::CoordBits-1:0] x, logic [ibtm_pkg::CoordBits-1:0] y,
        logic [ibtm_pkg::CoordBits-1:0] w, logic [ibtm_pkg::CoordBits-1:0] h);
        ibtm_pkg::in_item_t b;
        b.cmd = ibtm_pkg::CMD_BOX;
        b.box_x = x;
        b.box_y = y;
        b.box_width = w;
        b.box_height = h;
        return b;
    endfunction

    function automatic ibtm_pkg::in_item_t random_box();
        ibtm_pkg::in_item_t b, p;
        int r, span;
        r = $urandom_range(0, 99);
        if (last_frame.size() > 0 && r < 70)
        begin
            p = last_frame[$urandom_range(0, last_frame.size() - 1)];
            span = (r < 50) ? 4 : 40;
            b = make_box(nudge(p.box_x, span), nudge(p.box_y, span),
                         nudge(p.box_width, span), nudge(p.box_height, span));
        end
        else if (r < 82)
            b = make_box(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
        else if (r < 90)
            b = make_box(12'($urandom_range(0, 400)), 12'($urandom_range(0, 400)),
                         $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(0, 200)),
                         $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(0, 200)));
        else
            b = make_box(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)),
                         12'($urandom_range(1, 120)), 12'($urandom_range(1, 120)));
        return b;
    endfunction

    task automatic queue_box(input ibtm_pkg::in_item_t b);
        pending_requests = {pending_requests, b};
        this_frame = {this_frame, b};
    endtask

    task automatic queue_eof();
        ibtm_pkg::in_item_t e;
        e = '0;
        e.cmd = ibtm_pkg::CMD_EOF;
        e.box_x = 12'($urandom);
        e.box_y = 12'($urandom);
        e.box_width = 12'($urandom);
        e.box_height = 12'($urandom);
        pending_requests = {pending_requests, e};
        last_frame = this_frame;
        this_frame.delete();
    endtask

    // Waits until every request is in and every result is out, then lets the
    // tail of an end-of-frame request settle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_requests.size() > 0 || in_valid || expected_tracks.size() > 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx,
                             input logic [ibtm_pkg::ScoreBits-1:0] val);
        @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random frames: mostly a few faces, sometimes more than the list holds,
    // sometimes empty.
    task automatic queue_random_frames(input int n_items);
        int count, k;
        count = 0;
        while (count < n_items)
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
                k = $urandom_range(15, 20);
            else if (k == 1)
                k = 0;
            else
                k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++)
                queue_box(random_box());
            queue_eof();
            count += k + 1;
        end
    endtask

    logic [ibtm_pkg::ScoreBits-1:0] min_set[6];
    logic [ibtm_pkg::ScoreBits-1:0] max_set[6];

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = ibtm_pkg::REG_MIN_SCORE;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames at the reset thresholds: an empty box, the largest
        // box, two identical tracks for the tie rule, and a full-frame box.
        queue_box(make_box(12'd0, 12'd0, 12'd0, 12'd0));
        queue_box(make_box(12'd4095, 12'd4095, 12'd4095, 12'd4095));
        queue_box(make_box(12'd100, 12'd100, 12'd50, 12'd50));
        queue_box(make_box(12'd100, 12'd100, 12'd50, 12'd50));
        queue_box(make_box(12'd0, 12'd0, 12'd4095, 12'd4095));
        queue_eof();
        // Exact repeat replaces, a shifted copy averages, two empty boxes never match.
        queue_box(make_box(12'd100, 12'd100, 12'd50, 12'd50));
        queue_box(make_box(12'd110, 12'd105, 12'd50, 12'd50));
        queue_box(make_box(12'd4095, 12'd4095, 12'd4095, 12'd4095));
        queue_box(make_box(12'd0, 12'd0, 12'd0, 12'd0));
        queue_box(make_box(12'd1, 12'd1, 12'd4094, 12'd4094));
        queue_eof();
        queue_eof();
        // More boxes than the list holds in one frame.
        for (int i = 0; i < 18; i++)
            queue_box(make_box(12'(i * 200), 12'(i * 100), 12'd60, 12'd60));
        queue_eof();
        wait_idle();

        // Threshold settings, extremes first, each followed by random frames.
        min_set = '{17'd19661, 17'd0, 17'd65536, 17'd0, 17'd65535, 17'd0};
        max_set = '{17'd62259, 17'd0, 17'd65536, 17'd65536, 17'd1, 17'd0};
        min_set[5] = 17'($urandom_range(0, 65536));
        max_set[5] = 17'($urandom_range(0, 65536));
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(ibtm_pkg::REG_MIN_SCORE, min_set[ph]);
            write_reg(ibtm_pkg::REG_MAX_SCORE, max_set[ph]);
            queue_random_frames(160);
            for (int i = 0; i < 5; i++)
                queue_box(random_box());
            // Let everything drain in the middle of a frame, then carry on.
            if (ph == 0)
                wait_idle();
            queue_random_frames(160);
            wait_idle();
        end

        $display("Covered %0d frames and %0d threshold writes.", n_frames, n_cfg);
        $display("Results: %0d new, %0d averaged, %0d replaced.",
                 n_new, n_averaged, n_replaced);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Timeout with %0d results outstanding.", expected_tracks.size());
        $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

FILE: files.f
design/ibtm_pkg.sv
design/ibtm_ram.sv
design/iou_box_track_matcher_unit.sv
tb/tb_top.sv
